>>> rtl/core/p2e_pkg.sv
package p2e_pkg;

    localparam int CW  = 34;
    localparam int AW  = 34;
    localparam int RW  = 62;
    localparam int NSQ = 31;
    localparam int DW  = 13;

    localparam logic signed [AW-1:0] QUARTER_TURN = 34'sd1073741824;

    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef enum logic [2:0] {
        REG_OUT_WIDTH     = 3'd0,
        REG_OUT_HEIGHT    = 3'd1,
        REG_INV_FOCAL     = 3'd2,
        REG_ROT_ROW0      = 3'd3,
        REG_ROT_ROW1      = 3'd4,
        REG_ROT_ROW2      = 3'd5,
        REG_SRC_WIDTH_M1  = 3'd6,
        REG_SRC_HEIGHT_M1 = 3'd7
    } p2e_reg_t;

    typedef struct packed {
        logic [11:0] pix_x;
        logic [11:0] pix_y;
    } p2e_in_t;

    typedef struct packed {
        logic [22:0] src_x;
        logic [22:0] src_y;
    } p2e_out_t;

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [AW-1:0] ang;
        logic                 zero;
    } p2e_lane_t;

    typedef struct packed {
        p2e_lane_t       lon;
        p2e_lane_t       lat;
        logic [RW-1:0]   rem;
        logic [RW-1:0]   root;
    } p2e_work_t;

endpackage

>>> rtl/core/p2e_front.sv
module p2e_front
    import p2e_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  p2e_in_t         in_data,
    input  logic [DW-1:0]   width_c,
    input  logic [DW-1:0]   height_c,
    input  logic [23:0]     inv_focal,
    input  logic [53:0]     rot_row0,
    input  logic [53:0]     rot_row1,
    input  logic [53:0]     rot_row2,
    output logic            out_valid,
    input  logic            out_ready,
    output p2e_work_t       out_work
);

    localparam int NN = 6;
    localparam int NF = 13;

    logic [NF-1:0] vld_reg;
    logic [NF-1:0] adv;

    logic signed [17:0] m [3][3];
    logic [53:0]        rows [3];

    logic signed [13:0] dx_reg, dy_reg;
    logic signed [37:0] ray_reg [2];
    logic signed [55:0] prod_reg [3][2];
    logic signed [57:0] v_reg [3];
    logic signed [57:0] nv_reg [0:NN][3];
    logic [56:0]        nor_reg [0:NN];
    logic signed [30:0] xq_reg, yq_reg, zq_reg;
    logic [61:0]        sqx_reg, sqz_reg;
    p2e_work_t          work_reg;

    assign rows[0] = rot_row0;
    assign rows[1] = rot_row1;
    assign rows[2] = rot_row2;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                m[r][c] = $signed(rows[r][18*c +: 18]);
            end
        end
    end

    always_comb
    begin
        adv[NF-1] = !vld_reg[NF-1] || out_ready;
        for (int k = NF - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NF-1];
    assign out_work  = work_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NF; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ray, matrix product and magnitude
    logic signed [38:0] ray_full [2];
    logic [56:0]        abs_v [3];

    always_comb
    begin
        ray_full[0] = dx_reg * $signed({1'b0, inv_focal});
        ray_full[1] = dy_reg * $signed({1'b0, inv_focal});
        for (int r = 0; r < 3; r++)
        begin
            abs_v[r] = v_reg[r][57] ? 57'(-v_reg[r]) : v_reg[r][56:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            dx_reg <= $signed({1'b0, in_data.pix_x, 1'b0}) - $signed({1'b0, width_c - 13'd1});
            dy_reg <= $signed({1'b0, in_data.pix_y, 1'b0}) - $signed({1'b0, height_c - 13'd1});
        end
        if (adv[1])
        begin
            ray_reg[0] <= ray_full[0][37:0];
            ray_reg[1] <= ray_full[1][37:0];
        end
        if (adv[2])
        begin
            for (int r = 0; r < 3; r++)
            begin
                prod_reg[r][0] <= ray_reg[0] * m[r][0];
                prod_reg[r][1] <= ray_reg[1] * m[r][1];
            end
        end
        if (adv[3])
        begin
            for (int r = 0; r < 3; r++)
            begin
                v_reg[r] <= 58'(prod_reg[r][0]) + 58'(prod_reg[r][1])
                          + (58'(m[r][2]) <<< 25);
            end
        end
        if (adv[4])
        begin
            for (int r = 0; r < 3; r++)
            begin
                nv_reg[0][r] <= v_reg[r];
            end
            nor_reg[0] <= abs_v[0] | abs_v[1] | abs_v[2];
        end
    end

    // leading one of the largest magnitude moved to bit 56
    for (genvar k = 1; k <= NN; k++)
    begin : g_norm
        localparam int S = 64 >> k;
        logic hit;
        assign hit = (nor_reg[k-1][56 -: S] == '0);
        always_ff @(posedge clk)
        begin
            if (adv[4+k])
            begin
                nor_reg[k] <= hit ? (nor_reg[k-1] << S) : nor_reg[k-1];
                for (int r = 0; r < 3; r++)
                begin
                    nv_reg[k][r] <= hit ? (nv_reg[k-1][r] <<< S) : nv_reg[k-1][r];
                end
            end
        end
    end

    logic signed [30:0] xq, yq, zq;
    logic signed [61:0] sqx, sqz;

    always_comb
    begin
        xq  = $signed(nv_reg[NN][0][57:27]);
        yq  = $signed(nv_reg[NN][1][57:27]);
        zq  = $signed(nv_reg[NN][2][57:27]);
        sqx = xq * xq;
        sqz = zq * zq;
    end

    always_ff @(posedge clk)
    begin
        if (adv[11])
        begin
            xq_reg  <= xq;
            yq_reg  <= yq;
            zq_reg  <= zq;
            sqx_reg <= sqx;
            sqz_reg <= sqz;
        end
        if (adv[12])
        begin
            work_reg.lon.cx   <= CW'(zq_reg);
            work_reg.lon.cy   <= CW'(xq_reg);
            work_reg.lon.ang  <= '0;
            work_reg.lon.zero <= 1'b0;
            work_reg.lat.cx   <= '0;
            work_reg.lat.cy   <= CW'(yq_reg);
            work_reg.lat.ang  <= '0;
            work_reg.lat.zero <= 1'b0;
            work_reg.rem      <= sqx_reg + sqz_reg;
            work_reg.root     <= '0;
        end
    end

endmodule

>>> rtl/core/p2e_sqrt_cell.sv
module p2e_sqrt_cell
    import p2e_pkg::*;
#(
    parameter int K = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  p2e_work_t in_work,
    output logic      out_valid,
    input  logic      out_ready,
    output p2e_work_t out_work
);

    localparam logic [RW-1:0] BIT = RW'(1) << (60 - 2 * K);

    logic      vld_reg;
    p2e_work_t work_reg;
    p2e_work_t work_next;
    logic [RW-1:0] trial;

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_work  = work_reg;

    always_comb
    begin
        work_next = in_work;
        trial     = in_work.root + BIT;
        if (in_work.rem >= trial)
        begin
            work_next.rem  = in_work.rem - trial;
            work_next.root = (in_work.root >> 1) + BIT;
        end
        else
        begin
            work_next.root = in_work.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            work_reg <= work_next;
        end
    end

endmodule

>>> rtl/core/p2e_cordic_cell.sv
module p2e_cordic_cell
    import p2e_pkg::*;
#(
    parameter int I = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  p2e_work_t in_work,
    output logic      out_valid,
    input  logic      out_ready,
    output p2e_work_t out_work
);

    localparam logic signed [AW-1:0] STEP = AW'(ATAN_TURNS[I]);

    logic      vld_reg;
    p2e_work_t work_reg;
    p2e_work_t work_next;

    function automatic p2e_lane_t lane_step(p2e_lane_t l);
        p2e_lane_t r;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        r  = l;
        xs = l.cx >>> I;
        ys = l.cy >>> I;
        if (!l.cy[CW-1])
        begin
            r.cx  = l.cx + ys;
            r.cy  = l.cy - xs;
            r.ang = l.ang + STEP;
        end
        else
        begin
            r.cx  = l.cx - ys;
            r.cy  = l.cy + xs;
            r.ang = l.ang - STEP;
        end
        return r;
    endfunction

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_work  = work_reg;

    always_comb
    begin
        work_next     = in_work;
        work_next.lon = lane_step(in_work.lon);
        work_next.lat = lane_step(in_work.lat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            work_reg <= work_next;
        end
    end

endmodule

>>> rtl/core/perspective_to_equirect_coord_map.sv
// Maps each perspective-view pixel (pix_x, pix_y) to its equirectangular source
// position (src_x, src_y) in unsigned Q13.10. One transaction is taken per clock
// unless a stalled output has backed up the chain, and results leave in input
// order after ray, rotation and normalization in the front, the 2-bit-per-cell
// square root, a pre-rotation register, the CORDIC cells (CORDIC_STAGES, at most
// 32; longitude and latitude side by side) and the output registers. A stalled
// output holds the chain; empty stages still fill behind it. Registers are
// written through cfg_we/cfg_addr/cfg_wdata and should change only when idle.
module perspective_to_equirect_coord_map
    import p2e_pkg::*;
#(
    parameter int MAX_OUT_DIM   = 4096,
    parameter int MAX_SRC_DIM   = 8192,
    parameter int CORDIC_STAGES = 20
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [53:0]  cfg_wdata,
    input  logic         in_valid,
    output logic         in_ready,
    input  p2e_in_t      in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output p2e_out_t     out_data
);

    localparam int NC = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

    logic [DW-1:0] out_width_reg, out_height_reg, src_width_m1_reg, src_height_m1_reg;
    logic [23:0]   inv_focal_reg;
    logic [53:0]   rot_row0_reg, rot_row1_reg, rot_row2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_width_reg     <= 13'd1024;
            out_height_reg    <= 13'd1024;
            inv_focal_reg     <= 24'd16384;
            rot_row0_reg      <= 54'h10_0000_0000;
            rot_row1_reg      <= 54'h100_0000;
            rot_row2_reg      <= 54'h1_0000;
            src_width_m1_reg  <= 13'd2047;
            src_height_m1_reg <= 13'd1023;
        end
        else if (cfg_we)
        begin
            unique case (p2e_reg_t'(cfg_addr))
                REG_OUT_WIDTH:     out_width_reg     <= cfg_wdata[12:0];
                REG_OUT_HEIGHT:    out_height_reg    <= cfg_wdata[12:0];
                REG_INV_FOCAL:     inv_focal_reg     <= cfg_wdata[23:0];
                REG_ROT_ROW0:      rot_row0_reg      <= cfg_wdata;
                REG_ROT_ROW1:      rot_row1_reg      <= cfg_wdata;
                REG_ROT_ROW2:      rot_row2_reg      <= cfg_wdata;
                REG_SRC_WIDTH_M1:  src_width_m1_reg  <= cfg_wdata[12:0];
                REG_SRC_HEIGHT_M1: src_height_m1_reg <= cfg_wdata[12:0];
                default:           ;
            endcase
        end
    end

    // saturated sizes
    logic [DW-1:0] width_c, height_c, src_w_c, src_h_c;

    always_comb
    begin
        width_c  = (out_width_reg == '0) ? 13'd1
                 : ((32'(out_width_reg) > MAX_OUT_DIM) ? 13'(MAX_OUT_DIM) : out_width_reg);
        height_c = (out_height_reg == '0) ? 13'd1
                 : ((32'(out_height_reg) > MAX_OUT_DIM) ? 13'(MAX_OUT_DIM) : out_height_reg);
        src_w_c  = (32'(src_width_m1_reg) > MAX_SRC_DIM - 1) ? 13'(MAX_SRC_DIM - 1)
                 : src_width_m1_reg;
        src_h_c  = (32'(src_height_m1_reg) > MAX_SRC_DIM - 1) ? 13'(MAX_SRC_DIM - 1)
                 : src_height_m1_reg;
    end

    // front: ray, rotation, normalization, squares
    logic      sq_v [0:NSQ];
    logic      sq_r [0:NSQ];
    p2e_work_t sq_w [0:NSQ];

    p2e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .width_c   (width_c),
        .height_c  (height_c),
        .inv_focal (inv_focal_reg),
        .rot_row0  (rot_row0_reg),
        .rot_row1  (rot_row1_reg),
        .rot_row2  (rot_row2_reg),
        .out_valid (sq_v[0]),
        .out_ready (sq_r[0]),
        .out_work  (sq_w[0])
    );

    for (genvar k = 0; k < NSQ; k++)
    begin : g_sqrt
        p2e_sqrt_cell #(.K(k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_v[k]),
            .in_ready  (sq_r[k]),
            .in_work   (sq_w[k]),
            .out_valid (sq_v[k+1]),
            .out_ready (sq_r[k+1]),
            .out_work  (sq_w[k+1])
        );
    end

    // pre-rotation into the right half plane
    function automatic p2e_lane_t pre_rot(p2e_lane_t l);
        p2e_lane_t r;
        r      = l;
        r.zero = (l.cx == '0) && (l.cy == '0);
        r.ang  = '0;
        if (l.cx[CW-1])
        begin
            if (!l.cy[CW-1])
            begin
                r.cx  = l.cy;
                r.cy  = -l.cx;
                r.ang = QUARTER_TURN;
            end
            else
            begin
                r.cx  = -l.cy;
                r.cy  = l.cx;
                r.ang = -QUARTER_TURN;
            end
        end
        return r;
    endfunction

    logic      cd_v [0:NC];
    logic      cd_r [0:NC];
    p2e_work_t cd_w [0:NC];

    logic      pr_vld_reg;
    p2e_work_t pr_reg;
    p2e_work_t pr_next;
    p2e_lane_t lat_in;

    always_comb
    begin
        lat_in      = sq_w[NSQ].lat;
        lat_in.cx   = CW'(sq_w[NSQ].root[30:0]);
        pr_next     = sq_w[NSQ];
        pr_next.lon = pre_rot(sq_w[NSQ].lon);
        pr_next.lat = pre_rot(lat_in);
    end

    assign sq_r[NSQ] = !pr_vld_reg || cd_r[0];
    assign cd_v[0]   = pr_vld_reg;
    assign cd_w[0]   = pr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_vld_reg <= 1'b0;
        end
        else if (sq_r[NSQ])
        begin
            pr_vld_reg <= sq_v[NSQ];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_r[NSQ])
        begin
            pr_reg <= pr_next;
        end
    end

    for (genvar i = 0; i < NC; i++)
    begin : g_cordic
        p2e_cordic_cell #(.I(i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cd_v[i]),
            .in_ready  (cd_r[i]),
            .in_work   (cd_w[i]),
            .out_valid (cd_v[i+1]),
            .out_ready (cd_r[i+1]),
            .out_work  (cd_w[i+1])
        );
    end

    // angle to position
    logic        t1_vld_reg, t2_vld_reg;
    logic        adv1, adv2;
    logic [32:0] px_reg, py_reg;
    logic [32:0] px_next, py_next;
    logic signed [AW-1:0] lon_a, lat_a;
    logic signed [35:0]   pl, pt;
    logic [45:0] mx, my;
    p2e_out_t    out_reg;

    assign adv2       = !t2_vld_reg || out_ready;
    assign adv1       = !t1_vld_reg || adv2;
    assign cd_r[NC]   = adv1;
    assign out_valid  = t2_vld_reg;
    assign out_data   = out_reg;

    always_comb
    begin
        lon_a = cd_w[NC].lon.zero ? '0 : cd_w[NC].lon.ang;
        lat_a = cd_w[NC].lat.zero ? '0 : cd_w[NC].lat.ang;
        pl    = 36'(lon_a) + 36'sd2147483648;
        pt    = (36'(lat_a) <<< 1) + 36'sd2147483648;
        if (pl < 0)
        begin
            px_next = '0;
        end
        else if (pl > 36'sd4294967296)
        begin
            px_next = 33'h1_0000_0000;
        end
        else
        begin
            px_next = pl[32:0];
        end
        if (pt < 0)
        begin
            py_next = '0;
        end
        else if (pt > 36'sd4294967296)
        begin
            py_next = 33'h1_0000_0000;
        end
        else
        begin
            py_next = pt[32:0];
        end
        mx = 46'(px_reg) * 46'(src_w_c) + 46'd2097152;
        my = 46'(py_reg) * 46'(src_h_c) + 46'd2097152;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_vld_reg <= 1'b0;
            t2_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                t1_vld_reg <= cd_v[NC];
            end
            if (adv2)
            begin
                t2_vld_reg <= t1_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
        if (adv2)
        begin
            out_reg.src_x <= mx[44:22];
            out_reg.src_y <= my[44:22];
        end
    end

    // input only backs up behind a stalled output
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output backpressure");

    a_src_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.src_x <= {src_w_c, 10'b0}))
        else $error("src_x beyond source width");

    a_src_y_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.src_y <= {src_h_c, 10'b0}))
        else $error("src_y beyond source height");

    a_prerot_half: assert property (@(posedge clk) disable iff (!rst_n)
        pr_vld_reg |-> (!pr_reg.lon.cx[CW-1] && !pr_reg.lat.cx[CW-1]))
        else $error("pre-rotation left x negative");

endmodule
